/* rtl/psi_pkg.sv */
package psi_pkg;

  // fixed point and field widths
  localparam int FRAC_BITS = 16;
  localparam int DW        = 24;                // dimension width
  localparam int MW        = 32;                // mass width
  localparam int OW        = 48;                // moment width
  localparam int PW        = 83;                // shape polynomial width
  localparam int DENW      = 34;                // divisor width
  localparam int NSH       = 2 * FRAC_BITS;     // extra fraction bits in m*P
  localparam int NQW       = MW + PW - NSH;     // numerator width into divider
  localparam int CW        = 28;                // polynomial chunk per multiplier
  localparam int NCH       = (PW + CW - 1) / CW;
  localparam int DIV_ST    = OW + 1;            // divider stages

  // fixed divisors
  localparam logic [DENW-1:0] DEN_ONE    = DENW'(1);
  localparam logic [DENW-1:0] DEN_SPHERE = DENW'(5);
  localparam logic [DENW-1:0] DEN_TWELVE = DENW'(12);
  localparam logic [DENW-1:0] DEN_CYL_Z  = DENW'(2);

  typedef enum logic [2:0] {
    KIND_SPHERE   = 3'd0,
    KIND_BOX      = 3'd1,
    KIND_CAPSULE  = 3'd2,
    KIND_CYLINDER = 3'd3,
    KIND_MESH     = 3'd4,
    KIND_HFIELD   = 3'd5
  } kind_t;

  typedef struct packed {
    logic valid;
    logic err;
  } ctrl_t;

endpackage

/* rtl/psi_poly.sv */
module psi_poly
  import psi_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2:0]      in_kind,
  input  logic [MW-1:0]   in_m,
  input  logic [DW-1:0]   in_a,
  input  logic [DW-1:0]   in_b,
  input  logic [DW-1:0]   in_c,
  output ctrl_t           out_ctl,
  output logic [MW-1:0]   out_m,
  output logic [PW-1:0]   out_px,
  output logic [PW-1:0]   out_py,
  output logic [PW-1:0]   out_pz,
  output logic [DENW-1:0] out_dx,
  output logic [DENW-1:0] out_dy,
  output logic [DENW-1:0] out_dz
);

  typedef struct packed {
    logic [2:0]      kind;
    logic [MW-1:0]   m;
    logic [2*DW-1:0] a2;
    logic [2*DW+1:0] t3;
    logic [2*DW:0]   sbc;
    logic [2*DW:0]   sac;
    logic [2*DW:0]   sab;
    logic [DENW-1:0] d80;
    logic [30:0]     d10;
  } carry_t;

  logic [5:0] vld_r;

  // stage 1 registers
  logic [2:0]      kind1_r;
  logic [MW-1:0]   m1_r;
  logic [DW-1:0]   a1_r, b1_r;
  logic [2*DW-1:0] a2_1_r, b2_1_r, c2_1_r;
  logic [26:0]     s1_r, v1_r;
  logic [28:0]     k1_r;

  // stage 2 registers
  carry_t          cy2_r;
  logic [DW-1:0]   a2d_r, b2d_r;
  logic [54:0]     a83_2_r;
  logic [53:0]     ss2_r;
  logic [52:0]     akl2_r, akh2_r;

  // stage 3 registers
  carry_t          cy3_r;
  logic [DW-1:0]   a3d_r;
  logic [57:0]     u3_r;
  logic [48:0]     btl3_r, bth3_r;
  logic [76:0]     a2k3_r;

  // stage 4 registers
  carry_t          cy4_r;
  logic [76:0]     a2k4_r;
  logic [78:0]     p1_4_r;
  logic [52:0]     aul4_r, auh4_r;

  // stage 5 registers
  carry_t          cy5_r;
  logic [76:0]     a2k5_r;
  logic [78:0]     p1_5_r;
  logic [81:0]     p2_5_r;

  // stage 6 registers
  logic            err6_r;
  logic [MW-1:0]   m6_r;
  logic [PW-1:0]   px_r, py_r, pz_r;
  logic [DENW-1:0] dx_r, dy_r, dz_r;

  logic [73:0]     bt_sum;
  logic [PW-1:0]   pcx;
  logic            err_nxt;
  logic [PW-1:0]   px_nxt, py_nxt, pz_nxt;
  logic [DENW-1:0] dx_nxt, dy_nxt, dz_nxt;

  assign bt_sum = 74'(btl3_r) + (74'(bth3_r) << 25);
  assign pcx    = PW'(p1_5_r) + PW'(p2_5_r);

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], in_valid};
    end
  end

  // squares and linear terms
  always_ff @(posedge clk) begin
    if (en) begin
      kind1_r <= in_kind;
      m1_r    <= in_m;
      a1_r    <= in_a;
      b1_r    <= in_b;
      a2_1_r  <= (2*DW)'(in_a) * (2*DW)'(in_a);
      b2_1_r  <= (2*DW)'(in_b) * (2*DW)'(in_b);
      c2_1_r  <= (2*DW)'(in_c) * (2*DW)'(in_c);
      s1_r    <= {1'b0, in_b, 2'b00} + {2'b00, in_a, 1'b0} + {3'b000, in_a};
      v1_r    <= {3'b000, in_b} + {2'b00, in_b, 1'b0} + {1'b0, in_a, 2'b00};
      k1_r    <= {1'b0, in_b, 4'b0000} - {5'b00000, in_b} + {1'b0, in_a, 4'b0000};
    end
  end

  // square sums and first partial products
  always_ff @(posedge clk) begin
    if (en) begin
      cy2_r.kind <= kind1_r;
      cy2_r.m    <= m1_r;
      cy2_r.a2   <= a2_1_r;
      cy2_r.t3   <= {1'b0, a2_1_r, 1'b0} + {2'b00, a2_1_r} + {2'b00, b2_1_r};
      cy2_r.sbc  <= {1'b0, b2_1_r} + {1'b0, c2_1_r};
      cy2_r.sac  <= {1'b0, a2_1_r} + {1'b0, c2_1_r};
      cy2_r.sab  <= {1'b0, a2_1_r} + {1'b0, b2_1_r};
      cy2_r.d80  <= DENW'(v1_r) * DENW'(80);
      cy2_r.d10  <= 31'(v1_r) * 31'(10);
      a2d_r      <= a1_r;
      b2d_r      <= b1_r;
      a83_2_r    <= 55'(a2_1_r) * 55'(83);
      ss2_r      <= 54'(s1_r) * 54'(s1_r);
      akl2_r     <= 53'(a2_1_r[DW-1:0]) * 53'(k1_r);
      akh2_r     <= 53'(a2_1_r[2*DW-1:DW]) * 53'(k1_r);
    end
  end

  // hemisphere term and section products
  always_ff @(posedge clk) begin
    if (en) begin
      cy3_r  <= cy2_r;
      a3d_r  <= a2d_r;
      u3_r   <= 58'(a83_2_r) + 58'(ss2_r) * 58'(5);
      btl3_r <= 49'(b2d_r) * 49'(cy2_r.t3[24:0]);
      bth3_r <= 49'(b2d_r) * 49'(cy2_r.t3[49:25]);
      a2k3_r <= 77'(akl2_r) + (77'(akh2_r) << DW);
    end
  end

  // section term and radius products
  always_ff @(posedge clk) begin
    if (en) begin
      cy4_r  <= cy3_r;
      a2k4_r <= a2k3_r;
      p1_4_r <= (79'(bt_sum) << 4) + (79'(bt_sum) << 2);
      aul4_r <= 53'(a3d_r) * 53'(u3_r[28:0]);
      auh4_r <= 53'(a3d_r) * 53'(u3_r[57:29]);
    end
  end

  // combine radius products
  always_ff @(posedge clk) begin
    if (en) begin
      cy5_r  <= cy4_r;
      a2k5_r <= a2k4_r;
      p1_5_r <= p1_4_r;
      p2_5_r <= 82'(aul4_r) + (82'(auh4_r) << 29);
    end
  end

  // pick polynomial and divisor per shape
  always_comb begin
    err_nxt = 1'b0;
    px_nxt  = '0;
    py_nxt  = '0;
    pz_nxt  = '0;
    dx_nxt  = DEN_ONE;
    dy_nxt  = DEN_ONE;
    dz_nxt  = DEN_ONE;
    case (kind_t'(cy5_r.kind))
      KIND_SPHERE: begin
        px_nxt = PW'({cy5_r.a2, 1'b0});
        py_nxt = px_nxt;
        pz_nxt = px_nxt;
        dx_nxt = DEN_SPHERE;
        dy_nxt = DEN_SPHERE;
        dz_nxt = DEN_SPHERE;
      end
      KIND_BOX: begin
        px_nxt = PW'(cy5_r.sbc);
        py_nxt = PW'(cy5_r.sac);
        pz_nxt = PW'(cy5_r.sab);
        dx_nxt = DEN_TWELVE;
        dy_nxt = DEN_TWELVE;
        dz_nxt = DEN_TWELVE;
      end
      KIND_CAPSULE: begin
        px_nxt = pcx;
        py_nxt = pcx;
        pz_nxt = PW'(a2k5_r);
        // empty capsule: polynomials are zero, keep divisor at one
        if (cy5_r.d80 != '0) begin
          dx_nxt = cy5_r.d80;
          dy_nxt = cy5_r.d80;
          dz_nxt = DENW'(cy5_r.d10);
        end
      end
      KIND_CYLINDER: begin
        px_nxt = PW'(cy5_r.t3);
        py_nxt = px_nxt;
        pz_nxt = PW'(cy5_r.a2);
        dx_nxt = DEN_TWELVE;
        dy_nxt = DEN_TWELVE;
        dz_nxt = DEN_CYL_Z;
      end
      default: begin
        err_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      err6_r <= err_nxt;
      m6_r   <= cy5_r.m;
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      pz_r   <= pz_nxt;
      dx_r   <= dx_nxt;
      dy_r   <= dy_nxt;
      dz_r   <= dz_nxt;
    end
  end

  assign out_ctl.valid = vld_r[5];
  assign out_ctl.err   = err6_r;
  assign out_m  = m6_r;
  assign out_px = px_r;
  assign out_py = py_r;
  assign out_pz = pz_r;
  assign out_dx = dx_r;
  assign out_dy = dy_r;
  assign out_dz = dz_r;

endmodule

/* rtl/psi_mass_mul.sv */
module psi_mass_mul
  import psi_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  ctrl_t           in_ctl,
  input  logic [MW-1:0]   in_m,
  input  logic [PW-1:0]   in_p   [3],
  input  logic [DENW-1:0] in_d   [3],
  output ctrl_t           out_ctl,
  output logic [NQW-1:0]  out_n  [3],
  output logic [DENW-1:0] out_d  [3]
);

  localparam int PPW = MW + CW;
  localparam int NW  = MW + NCH * CW;

  ctrl_t           ctl1_r, ctl2_r;
  logic [PPW-1:0]  pp_r  [3][NCH];
  logic [DENW-1:0] d1_r  [3];
  logic [DENW-1:0] d2_r  [3];
  logic [NQW-1:0]  n2_r  [3];

  // advance control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
    end else if (en) begin
      ctl1_r <= in_ctl;
      ctl2_r <= ctl1_r;
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [NCH*CW-1:0] p_ext;
    logic [NW-1:0]     n_sum;

    assign p_ext = (NCH*CW)'(in_p[l]);

    // sum chunk products
    always_comb begin
      n_sum = '0;
      for (int j = 0; j < NCH; j++) begin
        n_sum = n_sum + (NW'(pp_r[l][j]) << (j * CW));
      end
    end

    // mass times polynomial chunks, then sum and drop extra fraction bits
    always_ff @(posedge clk) begin
      if (en) begin
        for (int j = 0; j < NCH; j++) begin
          pp_r[l][j] <= PPW'(in_m) * PPW'(p_ext[j*CW +: CW]);
        end
        d1_r[l] <= in_d[l];
        d2_r[l] <= d1_r[l];
        n2_r[l] <= n_sum[NSH +: NQW];
      end
    end

    assign out_n[l] = n2_r[l];
    assign out_d[l] = d2_r[l];
  end

  assign out_ctl = ctl2_r;

endmodule

/* rtl/psi_div.sv */
module psi_div
  import psi_pkg::*;
(
  input  logic            clk,
  input  logic            en,
  input  logic [NQW-1:0]  num,
  input  logic [DENW-1:0] den,
  output logic [OW-1:0]   quo
);

  logic [DENW-1:0] rem_r [DIV_ST];
  logic [OW-1:0]   low_r [DIV_ST];
  logic [OW-1:0]   q_r   [DIV_ST];
  logic [DENW-1:0] den_r [DIV_ST];
  logic            sat_r [DIV_ST];

  logic [DENW:0]   top;

  assign top = num[NQW-1:OW];

  // quotient at or above full scale saturates; otherwise seed remainder
  always_ff @(posedge clk) begin
    if (en) begin
      sat_r[0] <= top >= {1'b0, den};
      rem_r[0] <= top[DENW-1:0];
      low_r[0] <= num[OW-1:0];
      q_r[0]   <= '0;
      den_r[0] <= den;
    end
  end

  // one restoring step per stage
  for (genvar i = 1; i < DIV_ST; i++) begin : g_step
    logic [DENW:0] rs;
    logic [DENW:0] diff;
    logic          ge;

    assign rs   = {rem_r[i-1], low_r[i-1][OW-1]};
    assign diff = rs - {1'b0, den_r[i-1]};
    assign ge   = rs >= {1'b0, den_r[i-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? diff[DENW-1:0] : rs[DENW-1:0];
        low_r[i] <= {low_r[i-1][OW-2:0], 1'b0};
        q_r[i]   <= {q_r[i-1][OW-2:0], ge};
        den_r[i] <= den_r[i-1];
        sat_r[i] <= sat_r[i-1];
      end
    end
  end

  assign quo = sat_r[DIV_ST-1] ? '1 : q_r[DIV_ST-1];

endmodule

/* rtl/primitive_shape_inertia.sv */
// Principal moments of inertia of a uniform solid sphere, box, capsule or cylinder.
// Pipeline: 6 polynomial, 2 mass multiply and 49 divider stages.
// Throughput: one item per cycle while the output is not stalled; set by the one-bit-per-stage divider lanes.
// A stall at the output freezes the whole pipeline; nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears all valid bits; the pipeline starts empty.
module primitive_shape_inertia
  import psi_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,   // mass[31:0], dim_a[55:32], dim_b[79:56], dim_c[103:80]
  input  logic [2:0]   in_tuser,   // func[2:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata,  // inertia_x[47:0], inertia_y[95:48], inertia_z[143:96]
  output logic [0:0]   out_tuser   // error_code[0]
);

  logic            en;
  ctrl_t           poly_ctl, mul_ctl;
  logic [MW-1:0]   poly_m;
  logic [PW-1:0]   poly_p [3];
  logic [DENW-1:0] poly_d [3];
  logic [NQW-1:0]  mul_n  [3];
  logic [DENW-1:0] mul_d  [3];
  logic [OW-1:0]   quo    [3];
  ctrl_t           dctl_r [DIV_ST];

  // whole pipeline moves unless the output item is held
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  psi_poly u_poly (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .in_kind  (in_tuser),
    .in_m     (in_tdata[31:0]),
    .in_a     (in_tdata[55:32]),
    .in_b     (in_tdata[79:56]),
    .in_c     (in_tdata[103:80]),
    .out_ctl  (poly_ctl),
    .out_m    (poly_m),
    .out_px   (poly_p[0]),
    .out_py   (poly_p[1]),
    .out_pz   (poly_p[2]),
    .out_dx   (poly_d[0]),
    .out_dy   (poly_d[1]),
    .out_dz   (poly_d[2])
  );

  psi_mass_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_ctl  (poly_ctl),
    .in_m    (poly_m),
    .in_p    (poly_p),
    .in_d    (poly_d),
    .out_ctl (mul_ctl),
    .out_n   (mul_n),
    .out_d   (mul_d)
  );

  for (genvar l = 0; l < 3; l++) begin : g_div
    psi_div u_div (
      .clk (clk),
      .en  (en),
      .num (mul_n[l]),
      .den (mul_d[l]),
      .quo (quo[l])
    );
  end

  // carry valid and error alongside the divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_ST; i++) begin
        dctl_r[i] <= '0;
      end
    end else if (en) begin
      dctl_r[0] <= mul_ctl;
      for (int i = 1; i < DIV_ST; i++) begin
        dctl_r[i] <= dctl_r[i-1];
      end
    end
  end

  assign out_tvalid = dctl_r[DIV_ST-1].valid;
  assign out_tdata  = {quo[2], quo[1], quo[0]};
  assign out_tuser  = dctl_r[DIV_ST-1].err;

endmodule

/* sim/inertia_checker.sv */
`timescale 1ns / 1ps

module inertia_checker
  import psi_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [103:0] in_tdata,
  input  logic [2:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [143:0] out_tdata,
  input  logic [0:0]   out_tuser,
  output int           fail_count,
  output int           pending_count
);

  localparam logic [OW-1:0] MOMENT_MAX = {OW{1'b1}};

  typedef struct {
    logic [OW-1:0] ix;
    logic [OW-1:0] iy;
    logic [OW-1:0] iz;
    logic          err;
  } moments_t;

  moments_t moments_q[$];

  // divide, drop the extra fraction bits, saturate
  function automatic logic [OW-1:0] scale_moment(bit [255:0] num, bit [63:0] den);
    bit [255:0] q;
    q = (num / den) >> (2 * FRAC_BITS);
    if (q > MOMENT_MAX) return MOMENT_MAX;
    return q[OW-1:0];
  endfunction

  function automatic moments_t predict_moments(logic [2:0] kind, logic [31:0] m,
                                               logic [23:0] a, logic [23:0] b,
                                               logic [23:0] c);
    moments_t   r;
    bit [255:0] mm, aa, bb, cc, a2, b2, c2, v, s, part1, part2;
    mm = m; aa = a; bb = b; cc = c;
    a2 = aa * aa; b2 = bb * bb; c2 = cc * cc;
    r.ix = '0; r.iy = '0; r.iz = '0; r.err = 1'b0;
    case (kind)
      KIND_SPHERE: begin
        r.ix = scale_moment(mm * a2 * 2, 5);
        r.iy = r.ix;
        r.iz = r.ix;
      end
      KIND_BOX: begin
        r.ix = scale_moment(mm * (b2 + c2), 12);
        r.iy = scale_moment(mm * (a2 + c2), 12);
        r.iz = scale_moment(mm * (a2 + b2), 12);
      end
      KIND_CAPSULE: begin
        v = 3 * bb + 4 * aa;
        // an empty capsule gives zero moments, not an error
        if (v != 0) begin
          s = 4 * bb + 3 * aa;
          part1 = bb * (3 * a2 + b2) * 20;
          part2 = aa * (83 * a2 + 5 * (s * s));
          r.ix = scale_moment((part1 + part2) * mm, 64'(80 * v));
          r.iy = r.ix;
          r.iz = scale_moment(mm * a2 * (15 * bb + 16 * aa), 64'(10 * v));
        end
      end
      KIND_CYLINDER: begin
        r.ix = scale_moment(mm * (3 * a2 + b2), 12);
        r.iy = r.ix;
        r.iz = scale_moment(mm * a2, 2);
      end
      default: r.err = 1'b1;
    endcase
    return r;
  endfunction

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  // queue the prediction for each accepted item, compare each accepted result
  always @(posedge clk) begin
    moments_t e;
    int       errs;
    errs = 0;
    if (rst_n && in_tvalid && in_tready)
      moments_q.push_back(predict_moments(in_tuser, in_tdata[31:0], in_tdata[55:32],
                                          in_tdata[79:56], in_tdata[103:80]));
    if (rst_n && out_tvalid && out_tready) begin
      if (moments_q.size() == 0) begin
        $error("result with no item pending");
        errs++;
      end else begin
        e = moments_q.pop_front();
        if (out_tdata[47:0] !== e.ix) begin
          $error("inertia_x expected %0h got %0h", e.ix, out_tdata[47:0]);
          errs++;
        end
        if (out_tdata[95:48] !== e.iy) begin
          $error("inertia_y expected %0h got %0h", e.iy, out_tdata[95:48]);
          errs++;
        end
        if (out_tdata[143:96] !== e.iz) begin
          $error("inertia_z expected %0h got %0h", e.iz, out_tdata[143:96]);
          errs++;
        end
        if (out_tuser[0] !== e.err) begin
          $error("error_code expected %0h got %0h", e.err, out_tuser[0]);
          errs++;
        end
      end
    end
    fail_count    <= fail_count + errs;
    pending_count <= moments_q.size();
  end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import psi_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam logic [23:0] DIM_MAX  = '1;
  localparam logic [31:0] MASS_MAX = '1;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [103:0] in_tdata = '0;   // mass, dim_a, dim_b, dim_c
  logic [2:0]   in_tuser = '0;   // func
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [143:0] out_tdata;       // inertia_x, inertia_y, inertia_z
  logic [0:0]   out_tuser;       // error_code
  int           fail_count;
  int           pending_count;
  int           cycle_count = 0;
  int           tx_idle_pct = 21;
  int           rx_idle_pct = 72;

  primitive_shape_inertia uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  inertia_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // stall the result side at random
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // offer one item, with optional idle cycles first, and hold until accepted
  task automatic send_body(logic [2:0] kind, logic [31:0] m,
                           logic [23:0] a, logic [23:0] b, logic [23:0] c);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {c, b, a, m};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [23:0] pick_dim();
    case ($urandom_range(5))
      0:       return '0;
      1:       return DIM_MAX;
      2, 3:    return 24'($urandom_range(24'h3FFFF));
      default: return 24'($urandom());
    endcase
  endfunction

  function automatic logic [31:0] pick_mass();
    case ($urandom_range(4))
      0:       return '0;
      1:       return MASS_MAX;
      2:       return $urandom_range(32'h3FFFFF);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic [2:0] kind;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every kind at the extremes and at small values, including the two unused codes
    for (int k = 0; k < 8; k++) begin
      kind = 3'(k);
      send_body(kind, MASS_MAX, DIM_MAX, DIM_MAX, DIM_MAX);
      send_body(kind, 32'h0001_0000, 24'h01_0000, 24'h02_0000, 24'h03_0000);
    end
    // empty capsule, zero mass, one-lsb sizes, radius-only and length-only capsules, zero-radius cylinder, mesh
    send_body(KIND_CAPSULE, MASS_MAX, '0, '0, DIM_MAX);
    send_body(KIND_SPHERE, '0, DIM_MAX, DIM_MAX, DIM_MAX);
    send_body(KIND_BOX, 32'd1, 24'd1, 24'd1, 24'd1);
    send_body(KIND_CAPSULE, 32'h0001_0000, 24'h01_0000, '0, '0);
    send_body(KIND_CAPSULE, 32'h0001_0000, '0, 24'h01_0000, '0);
    send_body(KIND_CYLINDER, MASS_MAX, '0, DIM_MAX, '0);
    send_body(KIND_MESH, '0, '0, '0, '0);

    // random bodies over three idling phases
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 72 : 0;
      rx_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 21 : 0;
      for (int i = 0; i < 433; i++) begin
        if ($urandom_range(9) < 8) kind = 3'($urandom_range(3));
        else kind = 3'($urandom_range(7));
        send_body(kind, pick_mass(), pick_dim(), pick_dim(), pick_dim());
      end
    end
    in_tvalid <= 1'b0;

    // drain, then allow for the pipeline depth
    while (pending_count != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
